@@ design/pss_pkg.sv @@
// Shared types, codes and reset constants for the power supply sequencer.
`default_nettype none

package pss_pkg;

    localparam int LimitW = 20;

    typedef logic [LimitW-1:0] t_limit;

    // Reset values of the timeout limit registers.
    localparam t_limit STARTUP_STEP_RESET   = 20'd120000;
    localparam t_limit STARTUP_TOTAL_RESET  = 20'd240000;
    localparam t_limit SHUTDOWN_STEP_RESET  = 20'd60000;
    localparam t_limit SHUTDOWN_TOTAL_RESET = 20'd120000;

    // Configuration register indexes.
    localparam logic [1:0] REG_STARTUP_STEP   = 2'd0;
    localparam logic [1:0] REG_STARTUP_TOTAL  = 2'd1;
    localparam logic [1:0] REG_SHUTDOWN_STEP  = 2'd2;
    localparam logic [1:0] REG_SHUTDOWN_TOTAL = 2'd3;

    // Request types.
    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_COMMAND   = 3'd1;
    localparam logic [2:0] REQ_ON_TARGET = 3'd2;
    localparam logic [2:0] REQ_OFF       = 3'd3;
    localparam logic [2:0] REQ_ERROR     = 3'd4;
    localparam logic [2:0] REQ_LINK_LOST = 3'd5;

    // Command codes.
    localparam logic [1:0] CMD_CONFIGURE = 2'd0;
    localparam logic [1:0] CMD_STARTUP   = 2'd1;
    localparam logic [1:0] CMD_SHUTDOWN  = 2'd2;
    localparam logic [1:0] CMD_INTERRUPT = 2'd3;

    // Unit codes.
    localparam logic [1:0] UNIT_ARC        = 2'd0;
    localparam logic [1:0] UNIT_EXTRACTION = 2'd1;
    localparam logic [1:0] UNIT_FILAMENT   = 2'd2;
    localparam logic [1:0] UNIT_INJECTION  = 2'd3;

    // Unit commands.
    localparam logic [2:0] UC_NONE  = 3'd0;
    localparam logic [2:0] UC_START = 3'd1;
    localparam logic [2:0] UC_STOP  = 3'd2;
    localparam logic [2:0] UC_INTR  = 3'd3;
    localparam logic [2:0] UC_APPLY = 3'd4;

    // Fault codes.
    localparam logic [2:0] FLT_NONE          = 3'd0;
    localparam logic [2:0] FLT_STARTUP_STEP  = 3'd1;
    localparam logic [2:0] FLT_STARTUP_TOTAL = 3'd2;
    localparam logic [2:0] FLT_SHUTDOWN_STEP = 3'd3;
    localparam logic [2:0] FLT_SHUTDOWN_TOT  = 3'd4;
    localparam logic [2:0] FLT_UNIT_ERROR    = 3'd5;
    localparam logic [2:0] FLT_LINK_LOST     = 3'd6;

    // Phase codes as seen on the result port.
    localparam logic [3:0] PC_IDLE   = 4'd0;
    localparam logic [3:0] PC_SU_ARC = 4'd2;
    localparam logic [3:0] PC_SU_EXT = 4'd3;
    localparam logic [3:0] PC_SU_FIL = 4'd4;
    localparam logic [3:0] PC_SD_INJ = 4'd5;
    localparam logic [3:0] PC_SD_EXT = 4'd6;
    localparam logic [3:0] PC_SD_FIL = 4'd7;
    localparam logic [3:0] PC_SD_ARC = 4'd8;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_SU_ARC = 8'b0000_0010,
        PH_SU_EXT = 8'b0000_0100,
        PH_SU_FIL = 8'b0000_1000,
        PH_SD_INJ = 8'b0001_0000,
        PH_SD_EXT = 8'b0010_0000,
        PH_SD_FIL = 8'b0100_0000,
        PH_SD_ARC = 8'b1000_0000
    } t_phase;

    function automatic logic [3:0] phase_code(input t_phase ph);
        logic [3:0] code;
        case (ph)
            PH_SU_ARC: code = PC_SU_ARC;
            PH_SU_EXT: code = PC_SU_EXT;
            PH_SU_FIL: code = PC_SU_FIL;
            PH_SD_INJ: code = PC_SD_INJ;
            PH_SD_EXT: code = PC_SD_EXT;
            PH_SD_FIL: code = PC_SD_FIL;
            PH_SD_ARC: code = PC_SD_ARC;
            default:   code = PC_IDLE;
        endcase
        return code;
    endfunction

    // Unit that a phase starts or stops.
    function automatic logic [1:0] phase_unit(input t_phase ph);
        logic [1:0] u;
        case (ph)
            PH_SU_EXT: u = UNIT_EXTRACTION;
            PH_SU_FIL: u = UNIT_FILAMENT;
            PH_SD_INJ: u = UNIT_INJECTION;
            PH_SD_EXT: u = UNIT_EXTRACTION;
            PH_SD_FIL: u = UNIT_FILAMENT;
            default:   u = UNIT_ARC;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ design/power_supply_sequencer.sv @@
// Event-driven startup and shutdown sequencer for four supply units.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------------
//   in      | to block  | i_in_valid / o_in_stall    | i_req_type, i_command_code, i_unit
//   out     | from blk  | o_out_valid / i_out_stall  | o_phase, o_unit_command, ...
//   config  | to block  | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Every event is decoded against the phase and the two tick counters, and its result
// lands in the output register at the edge of the transfer, so one event is taken per
// cycle while the input is not stalled. The output register holds a result while the
// consumer stalls, and only then is the input stalled. Reset is synchronous and returns
// the phase to idle, clears the counters and loads the default limits.
`default_nettype none

module power_supply_sequencer #(
    parameter int COUNT_BITS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [1:0]  i_command_code,
    input  wire logic [1:0]  i_unit,

    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [3:0]  o_phase,
    output      logic [2:0]  o_unit_command,
    output      logic [1:0]  o_command_target,
    output      logic        o_startup_done,
    output      logic        o_shutdown_done,
    output      logic [2:0]  o_fault,
    output      logic [1:0]  o_fault_unit,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    localparam int CmpW = (COUNT_BITS > pss_pkg::LimitW) ? COUNT_BITS : pss_pkg::LimitW;

    typedef logic [COUNT_BITS-1:0] t_count;

    // Configuration registers.
    pss_pkg::t_limit r_su_step_lim, r_su_total_lim, r_sd_step_lim, r_sd_total_lim;

    // Sequencer state.
    pss_pkg::t_phase r_phase, n_phase;
    t_count          r_step, n_step, r_total, n_total;

    // Output register.
    logic       r_out_valid;
    logic [3:0] r_phase_out;
    logic [2:0] r_ucmd, n_ucmd;
    logic [1:0] r_target, n_target;
    logic       r_su_done, n_su_done, r_sd_done, n_sd_done;
    logic [2:0] r_fault, n_fault;
    logic [1:0] r_funit, n_funit;

    logic            in_xfer, cfg_wr;
    logic            in_startup, in_shutdown, active;
    logic [1:0]      cur_unit;
    t_count          step_inc, total_inc;
    pss_pkg::t_limit step_lim, total_lim;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_su_step_lim  <= pss_pkg::STARTUP_STEP_RESET;
            r_su_total_lim <= pss_pkg::STARTUP_TOTAL_RESET;
            r_sd_step_lim  <= pss_pkg::SHUTDOWN_STEP_RESET;
            r_sd_total_lim <= pss_pkg::SHUTDOWN_TOTAL_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pss_pkg::REG_STARTUP_STEP:   r_su_step_lim  <= pwdata[pss_pkg::LimitW-1:0];
                pss_pkg::REG_STARTUP_TOTAL:  r_su_total_lim <= pwdata[pss_pkg::LimitW-1:0];
                pss_pkg::REG_SHUTDOWN_STEP:  r_sd_step_lim  <= pwdata[pss_pkg::LimitW-1:0];
                pss_pkg::REG_SHUTDOWN_TOTAL: r_sd_total_lim <= pwdata[pss_pkg::LimitW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pss_pkg::REG_STARTUP_STEP:   prdata = 32'(r_su_step_lim);
            pss_pkg::REG_STARTUP_TOTAL:  prdata = 32'(r_su_total_lim);
            pss_pkg::REG_SHUTDOWN_STEP:  prdata = 32'(r_sd_step_lim);
            pss_pkg::REG_SHUTDOWN_TOTAL: prdata = 32'(r_sd_total_lim);
            default:                     prdata = '0;
        endcase
    end

    assign in_startup = (r_phase == pss_pkg::PH_SU_ARC) || (r_phase == pss_pkg::PH_SU_EXT)
                     || (r_phase == pss_pkg::PH_SU_FIL);
    assign in_shutdown = (r_phase == pss_pkg::PH_SD_INJ) || (r_phase == pss_pkg::PH_SD_EXT)
                      || (r_phase == pss_pkg::PH_SD_FIL) || (r_phase == pss_pkg::PH_SD_ARC);
    assign active    = in_startup || in_shutdown;
    assign cur_unit  = pss_pkg::phase_unit(r_phase);
    assign step_lim  = in_startup ? r_su_step_lim : r_sd_step_lim;
    assign total_lim = in_startup ? r_su_total_lim : r_sd_total_lim;

    // Elapsed counts stick at all ones.
    assign step_inc  = (&r_step) ? r_step : r_step + 1'b1;
    assign total_inc = (&r_total) ? r_total : r_total + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_step    = r_step;
        n_total   = r_total;
        n_ucmd    = pss_pkg::UC_NONE;
        n_target  = pss_pkg::UNIT_ARC;
        n_su_done = 1'b0;
        n_sd_done = 1'b0;
        n_fault   = pss_pkg::FLT_NONE;
        n_funit   = pss_pkg::UNIT_ARC;

        case (i_req_type)
            pss_pkg::REQ_TICK: begin
                if (active) begin
                    n_step  = step_inc;
                    n_total = total_inc;
                    // The step timeout wins when both expire on the same tick.
                    if (CmpW'(step_inc) >= CmpW'(step_lim)) begin
                        n_fault = in_startup ? pss_pkg::FLT_STARTUP_STEP
                                             : pss_pkg::FLT_SHUTDOWN_STEP;
                        n_funit = cur_unit;
                        n_phase = pss_pkg::PH_IDLE;
                    end else if (CmpW'(total_inc) >= CmpW'(total_lim)) begin
                        n_fault = in_startup ? pss_pkg::FLT_STARTUP_TOTAL
                                             : pss_pkg::FLT_SHUTDOWN_TOT;
                        n_phase = pss_pkg::PH_IDLE;
                    end
                end
            end
            pss_pkg::REQ_COMMAND: begin
                n_step  = '0;
                n_total = '0;
                case (i_command_code)
                    pss_pkg::CMD_CONFIGURE: begin
                        n_ucmd  = pss_pkg::UC_APPLY;
                        n_phase = pss_pkg::PH_IDLE;
                    end
                    pss_pkg::CMD_STARTUP: begin
                        n_ucmd   = pss_pkg::UC_START;
                        n_target = pss_pkg::UNIT_ARC;
                        n_phase  = pss_pkg::PH_SU_ARC;
                    end
                    pss_pkg::CMD_SHUTDOWN: begin
                        n_ucmd   = pss_pkg::UC_STOP;
                        n_target = pss_pkg::UNIT_INJECTION;
                        n_phase  = pss_pkg::PH_SD_INJ;
                    end
                    default: begin
                        n_ucmd  = pss_pkg::UC_INTR;
                        n_phase = pss_pkg::PH_IDLE;
                    end
                endcase
            end
            pss_pkg::REQ_ON_TARGET: begin
                if (in_startup && i_unit == cur_unit) begin
                    n_step = '0;
                    case (r_phase)
                        pss_pkg::PH_SU_ARC: begin
                            n_phase  = pss_pkg::PH_SU_EXT;
                            n_ucmd   = pss_pkg::UC_START;
                            n_target = pss_pkg::UNIT_EXTRACTION;
                        end
                        pss_pkg::PH_SU_EXT: begin
                            n_phase  = pss_pkg::PH_SU_FIL;
                            n_ucmd   = pss_pkg::UC_START;
                            n_target = pss_pkg::UNIT_FILAMENT;
                        end
                        default: begin
                            n_phase   = pss_pkg::PH_IDLE;
                            n_su_done = 1'b1;
                        end
                    endcase
                end
            end
            pss_pkg::REQ_OFF: begin
                if (in_shutdown && i_unit == cur_unit) begin
                    n_step = '0;
                    case (r_phase)
                        pss_pkg::PH_SD_INJ: begin
                            n_phase  = pss_pkg::PH_SD_EXT;
                            n_ucmd   = pss_pkg::UC_STOP;
                            n_target = pss_pkg::UNIT_EXTRACTION;
                        end
                        pss_pkg::PH_SD_EXT: begin
                            n_phase  = pss_pkg::PH_SD_FIL;
                            n_ucmd   = pss_pkg::UC_STOP;
                            n_target = pss_pkg::UNIT_FILAMENT;
                        end
                        pss_pkg::PH_SD_FIL: begin
                            n_phase  = pss_pkg::PH_SD_ARC;
                            n_ucmd   = pss_pkg::UC_STOP;
                            n_target = pss_pkg::UNIT_ARC;
                        end
                        default: begin
                            n_phase   = pss_pkg::PH_IDLE;
                            n_sd_done = 1'b1;
                        end
                    endcase
                end
            end
            pss_pkg::REQ_ERROR: begin
                if (active) begin
                    n_fault = pss_pkg::FLT_UNIT_ERROR;
                    n_funit = i_unit;
                    n_phase = pss_pkg::PH_IDLE;
                end
            end
            pss_pkg::REQ_LINK_LOST: begin
                if (active) begin
                    n_fault = pss_pkg::FLT_LINK_LOST;
                    n_ucmd  = pss_pkg::UC_INTR;
                    n_phase = pss_pkg::PH_IDLE;
                end
            end
            default: ;
        endcase

        // Idle always holds both counts at zero.
        if (n_phase == pss_pkg::PH_IDLE) begin
            n_step  = '0;
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pss_pkg::PH_IDLE;
            r_step      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_phase <= n_phase;
                r_step  <= n_step;
                r_total <= n_total;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_phase_out <= pss_pkg::phase_code(n_phase);
            r_ucmd      <= n_ucmd;
            r_target    <= n_target;
            r_su_done   <= n_su_done;
            r_sd_done   <= n_sd_done;
            r_fault     <= n_fault;
            r_funit     <= n_funit;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_phase          = r_phase_out;
    assign o_unit_command   = r_ucmd;
    assign o_command_target = r_target;
    assign o_startup_done   = r_su_done;
    assign o_shutdown_done  = r_sd_done;
    assign o_fault          = r_fault;
    assign o_fault_unit     = r_funit;

endmodule

`default_nettype wire

@@ bench/tb_power_supply_sequencer.sv @@
// Self-checking testbench for the power supply sequencer: event stream in, one status per event out.
`default_nettype none

module tb_power_supply_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CountW     = 20;
    localparam int CycleLimit = 200000;

    typedef struct packed {
        logic [2:0] req;
        logic [1:0] cmd;
        logic [1:0] unit;
    } t_event;

    typedef struct packed {
        logic [3:0] phase;
        logic [2:0] ucmd;
        logic [1:0] target;
        logic       su_done;
        logic       sd_done;
        logic [2:0] fault;
        logic [1:0] funit;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [2:0]  req_type = '0;
    logic [1:0]  command_code = '0;
    logic [1:0]  unit_sel = '0;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    wire logic        o_in_stall;
    wire logic        o_out_valid;
    wire logic [3:0]  o_phase;
    wire logic [2:0]  o_unit_command;
    wire logic [1:0]  o_command_target;
    wire logic        o_startup_done;
    wire logic        o_shutdown_done;
    wire logic [2:0]  o_fault;
    wire logic [1:0]  o_fault_unit;
    wire logic [31:0] prdata;
    wire logic        pready;

    power_supply_sequencer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (req_type),
        .i_command_code   (command_code),
        .i_unit           (unit_sel),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_phase          (o_phase),
        .o_unit_command   (o_unit_command),
        .o_command_target (o_command_target),
        .o_startup_done   (o_startup_done),
        .o_shutdown_done  (o_shutdown_done),
        .o_fault          (o_fault),
        .o_fault_unit     (o_fault_unit),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #4 i_clk = ~i_clk;

    // Sequencer state as the checker sees it.
    pss_pkg::t_limit   su_step_lim  = pss_pkg::STARTUP_STEP_RESET;
    pss_pkg::t_limit   su_total_lim = pss_pkg::STARTUP_TOTAL_RESET;
    pss_pkg::t_limit   sd_step_lim  = pss_pkg::SHUTDOWN_STEP_RESET;
    pss_pkg::t_limit   sd_total_lim = pss_pkg::SHUTDOWN_TOTAL_RESET;
    logic [3:0]        seq_phase    = pss_pkg::PC_IDLE;
    logic [CountW-1:0] step_ticks   = '0;
    logic [CountW-1:0] total_ticks  = '0;

    t_event  event_backlog[$];
    t_status status_due[$];
    int      mismatches = 0;
    int      statuses_seen = 0;
    int      mix_count = 0;
    int      cycle_count = 0;
    bit      calm = 1'b0;

    function automatic logic [1:0] unit_of_phase(input logic [3:0] ph);
        case (ph)
            pss_pkg::PC_SU_EXT, pss_pkg::PC_SD_EXT: return pss_pkg::UNIT_EXTRACTION;
            pss_pkg::PC_SU_FIL, pss_pkg::PC_SD_FIL: return pss_pkg::UNIT_FILAMENT;
            pss_pkg::PC_SD_INJ:                     return pss_pkg::UNIT_INJECTION;
            default:                                return pss_pkg::UNIT_ARC;
        endcase
    endfunction

    function automatic t_status advance_sequencer(input t_event ev);
        t_status         r;
        logic [3:0]      ph;
        logic            startup;
        logic            active;
        pss_pkg::t_limit step_lim;
        pss_pkg::t_limit total_lim;
        r = '0;
        ph = seq_phase;
        startup = (ph >= pss_pkg::PC_SU_ARC) && (ph <= pss_pkg::PC_SU_FIL);
        active = startup || ((ph >= pss_pkg::PC_SD_INJ) && (ph <= pss_pkg::PC_SD_ARC));
        case (ev.req)
            pss_pkg::REQ_TICK: begin
                if (active) begin
                    if (step_ticks != '1) step_ticks = step_ticks + 1'b1;
                    if (total_ticks != '1) total_ticks = total_ticks + 1'b1;
                    step_lim = startup ? su_step_lim : sd_step_lim;
                    total_lim = startup ? su_total_lim : sd_total_lim;
                    // The step timeout wins when both expire on the same tick.
                    if (step_ticks >= step_lim) begin
                        r.fault = startup ? pss_pkg::FLT_STARTUP_STEP
                                          : pss_pkg::FLT_SHUTDOWN_STEP;
                        r.funit = unit_of_phase(ph);
                        ph = pss_pkg::PC_IDLE;
                    end else if (total_ticks >= total_lim) begin
                        r.fault = startup ? pss_pkg::FLT_STARTUP_TOTAL
                                          : pss_pkg::FLT_SHUTDOWN_TOT;
                        ph = pss_pkg::PC_IDLE;
                    end
                end
            end
            pss_pkg::REQ_COMMAND: begin
                step_ticks = '0;
                total_ticks = '0;
                case (ev.cmd)
                    pss_pkg::CMD_CONFIGURE: begin
                        r.ucmd = pss_pkg::UC_APPLY;
                        ph = pss_pkg::PC_IDLE;
                    end
                    pss_pkg::CMD_STARTUP: begin
                        ph = pss_pkg::PC_SU_ARC;
                        r.ucmd = pss_pkg::UC_START;
                        r.target = unit_of_phase(ph);
                    end
                    pss_pkg::CMD_SHUTDOWN: begin
                        ph = pss_pkg::PC_SD_INJ;
                        r.ucmd = pss_pkg::UC_STOP;
                        r.target = unit_of_phase(ph);
                    end
                    default: begin
                        r.ucmd = pss_pkg::UC_INTR;
                        ph = pss_pkg::PC_IDLE;
                    end
                endcase
            end
            pss_pkg::REQ_ON_TARGET: begin
                if (startup && ev.unit == unit_of_phase(ph)) begin
                    step_ticks = '0;
                    if (ph == pss_pkg::PC_SU_FIL) begin
                        ph = pss_pkg::PC_IDLE;
                        r.su_done = 1'b1;
                    end else begin
                        ph = ph + 1'b1;
                        r.ucmd = pss_pkg::UC_START;
                        r.target = unit_of_phase(ph);
                    end
                end
            end
            pss_pkg::REQ_OFF: begin
                if (active && !startup && ev.unit == unit_of_phase(ph)) begin
                    step_ticks = '0;
                    if (ph == pss_pkg::PC_SD_ARC) begin
                        ph = pss_pkg::PC_IDLE;
                        r.sd_done = 1'b1;
                    end else begin
                        ph = ph + 1'b1;
                        r.ucmd = pss_pkg::UC_STOP;
                        r.target = unit_of_phase(ph);
                    end
                end
            end
            pss_pkg::REQ_ERROR: begin
                if (active) begin
                    r.fault = pss_pkg::FLT_UNIT_ERROR;
                    r.funit = ev.unit;
                    ph = pss_pkg::PC_IDLE;
                end
            end
            pss_pkg::REQ_LINK_LOST: begin
                if (active) begin
                    r.fault = pss_pkg::FLT_LINK_LOST;
                    r.ucmd = pss_pkg::UC_INTR;
                    ph = pss_pkg::PC_IDLE;
                end
            end
            default: ;
        endcase
        if (ph == pss_pkg::PC_IDLE) begin
            step_ticks = '0;
            total_ticks = '0;
        end
        seq_phase = ph;
        r.phase = ph;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("status %0d %s: got %0d, want %0d",
                                      statuses_seen, name, got, want));
    endtask

    // Event driver: presents the next pending event once the current transfer is done.
    always @(posedge i_clk) begin : event_driver
        t_event nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (event_backlog.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
                nxt = event_backlog.pop_front();
                in_valid <= 1'b1;
                req_type <= nxt.req;
                command_code <= nxt.cmd;
                unit_sel <= nxt.unit;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Status monitor: checks each output transfer, then predicts from each input transfer.
    always @(posedge i_clk) begin : status_monitor
        t_status want;
        t_event  ev;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (status_due.size() == 0) begin
                    report_mismatch($sformatf("status %0d arrived with none pending",
                                              statuses_seen));
                end else begin
                    want = status_due.pop_front();
                    check_field("phase", o_phase, want.phase);
                    check_field("unit_command", o_unit_command, want.ucmd);
                    check_field("command_target", o_command_target, want.target);
                    check_field("startup_done", o_startup_done, want.su_done);
                    check_field("shutdown_done", o_shutdown_done, want.sd_done);
                    check_field("fault", o_fault, want.fault);
                    check_field("fault_unit", o_fault_unit, want.funit);
                end
                statuses_seen++;
            end
            if (in_valid && !o_in_stall) begin
                ev.req = req_type;
                ev.cmd = command_code;
                ev.unit = unit_sel;
                status_due.push_back(advance_sequencer(ev));
            end
            out_stall <= !calm && ($urandom_range(99) < 9);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_limit(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // The register takes the value at this edge.
        case (idx)
            pss_pkg::REG_STARTUP_STEP:  su_step_lim = value[pss_pkg::LimitW-1:0];
            pss_pkg::REG_STARTUP_TOTAL: su_total_lim = value[pss_pkg::LimitW-1:0];
            pss_pkg::REG_SHUTDOWN_STEP: sd_step_lim = value[pss_pkg::LimitW-1:0];
            default:                    sd_total_lim = value[pss_pkg::LimitW-1:0];
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_limits(input logic [31:0] su_step, input logic [31:0] su_total,
                                input logic [31:0] sd_step, input logic [31:0] sd_total);
        write_limit(pss_pkg::REG_STARTUP_STEP, su_step);
        write_limit(pss_pkg::REG_STARTUP_TOTAL, su_total);
        write_limit(pss_pkg::REG_SHUTDOWN_STEP, sd_step);
        write_limit(pss_pkg::REG_SHUTDOWN_TOTAL, sd_total);
    endtask

    // Waits until every queued event has been taken and every status has come back.
    task automatic drain();
        while (event_backlog.size() > 0 || in_valid || status_due.size() > 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic add_event(input logic [2:0] req, input logic [1:0] cmd,
                             input logic [1:0] unit, input bit counted);
        t_event ev;
        ev.req = req;
        ev.cmd = cmd;
        ev.unit = unit;
        event_backlog.push_back(ev);
        if (counted) mix_count++;
    endtask

    task automatic add_ticks(input int n);
        for (int i = 0; i < n; i++)
            add_event(pss_pkg::REQ_TICK, 2'($urandom), 2'($urandom), 1'b1);
    endtask

    function automatic int tick_span(input pss_pkg::t_limit lim);
        return (lim < 30) ? int'(lim) + 2 : 6;
    endfunction

    // One startup or shutdown sequence, mostly well formed, sometimes cut short.
    task automatic add_run(input bit startup);
        logic [1:0] order[4];
        logic [2:0] kind;
        logic [2:0] other;
        int         steps;
        int         span;
        int         roll;
        if (startup) begin
            order = '{pss_pkg::UNIT_ARC, pss_pkg::UNIT_EXTRACTION, pss_pkg::UNIT_FILAMENT,
                      pss_pkg::UNIT_ARC};
            steps = 3;
            kind = pss_pkg::REQ_ON_TARGET;
            other = pss_pkg::REQ_OFF;
            span = tick_span(su_step_lim);
            add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_STARTUP, 2'($urandom), 1'b1);
        end else begin
            order = '{pss_pkg::UNIT_INJECTION, pss_pkg::UNIT_EXTRACTION,
                      pss_pkg::UNIT_FILAMENT, pss_pkg::UNIT_ARC};
            steps = 4;
            kind = pss_pkg::REQ_OFF;
            other = pss_pkg::REQ_ON_TARGET;
            span = tick_span(sd_step_lim);
            add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_SHUTDOWN, 2'($urandom), 1'b1);
        end
        for (int i = 0; i < steps; i++) begin
            add_ticks($urandom_range(0, span));
            if ($urandom_range(99) < 15) begin
                if ($urandom_range(1))
                    add_event(kind, 2'($urandom), order[i] + 2'($urandom_range(1, 3)), 1'b0);
                else
                    add_event(other, 2'($urandom), 2'($urandom), 1'b0);
            end
            roll = $urandom_range(99);
            if (roll < 4) begin
                add_event(pss_pkg::REQ_ERROR, 2'($urandom), 2'($urandom), 1'b1);
                return;
            end else if (roll < 7) begin
                add_event(pss_pkg::REQ_LINK_LOST, 2'($urandom), 2'($urandom), 1'b1);
                return;
            end else if (roll < 10) begin
                add_event(pss_pkg::REQ_COMMAND, 2'($urandom), 2'($urandom), 1'b1);
                return;
            end
            add_event(kind, 2'($urandom), order[i], 1'b1);
        end
    endtask

    task automatic add_random_mix(input int budget);
        int goal;
        int roll;
        logic [2:0] req;
        goal = mix_count + budget;
        while (mix_count < goal) begin
            roll = $urandom_range(99);
            if (roll < 40) begin
                add_run(1'b1);
            end else if (roll < 75) begin
                add_run(1'b0);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    req = 3'($urandom_range(0, 7));
                    add_event(req, 2'($urandom), 2'($urandom), req <= pss_pkg::REQ_LINK_LOST);
                end
            end
        end
    endtask

    task automatic add_directed();
        // Everything but a command is swallowed in idle.
        add_event(pss_pkg::REQ_TICK, pss_pkg::CMD_INTERRUPT, pss_pkg::UNIT_INJECTION, 1'b0);
        add_event(pss_pkg::REQ_OFF, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_INJECTION, 1'b0);
        add_event(pss_pkg::REQ_ON_TARGET, pss_pkg::CMD_INTERRUPT, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_ERROR, pss_pkg::CMD_STARTUP, pss_pkg::UNIT_INJECTION, 1'b0);
        add_event(pss_pkg::REQ_LINK_LOST, pss_pkg::CMD_SHUTDOWN, pss_pkg::UNIT_FILAMENT, 1'b0);
        add_event(3'd6, pss_pkg::CMD_INTERRUPT, pss_pkg::UNIT_INJECTION, 1'b0);
        add_event(3'd7, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_INJECTION, 1'b0);
        add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_INTERRUPT, pss_pkg::UNIT_ARC, 1'b0);
        // Full startup with stray events along the way.
        add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_STARTUP, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_ON_TARGET, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_EXTRACTION,
                  1'b0);
        add_event(pss_pkg::REQ_OFF, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_TICK, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_ON_TARGET, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_ON_TARGET, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_EXTRACTION,
                  1'b0);
        add_event(pss_pkg::REQ_ON_TARGET, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_FILAMENT,
                  1'b0);
        // Full shutdown.
        add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_SHUTDOWN, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_OFF, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_INJECTION, 1'b0);
        add_event(pss_pkg::REQ_TICK, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_OFF, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_EXTRACTION, 1'b0);
        add_event(pss_pkg::REQ_OFF, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_FILAMENT, 1'b0);
        add_event(pss_pkg::REQ_OFF, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_ARC, 1'b0);
        // Aborts and restarts from active phases.
        add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_STARTUP, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_ERROR, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_FILAMENT, 1'b0);
        add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_SHUTDOWN, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_LINK_LOST, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_STARTUP, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_SHUTDOWN, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_INTERRUPT, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_SHUTDOWN, pss_pkg::UNIT_ARC, 1'b0);
        add_event(pss_pkg::REQ_COMMAND, pss_pkg::CMD_CONFIGURE, pss_pkg::UNIT_ARC, 1'b0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_directed();
        drain();

        apply_limits(5, 12, 4, 9);
        add_random_mix(260);
        drain();

        apply_limits(0, 0, 0, 0);
        add_random_mix(200);
        drain();

        // A long stretch without idling on either side.
        calm = 1'b1;
        apply_limits(32'hFFFFF, 32'hFFFFF, 32'hFFFFF, 32'hFFFFF);
        add_random_mix(300);
        drain();
        calm = 1'b0;

        // Step and total limits equal, so both expire on the same tick.
        apply_limits(6, 6, 3, 3);
        add_random_mix(260);
        drain();

        apply_limits($urandom_range(1, 40), $urandom_range(1, 40),
                     $urandom_range(1, 40), $urandom_range(1, 40));
        add_random_mix(260);
        drain();

        apply_limits(1, 1, 1, 1);
        add_random_mix(150);
        drain();

        apply_limits($urandom, $urandom, $urandom, $urandom);
        add_random_mix(210);
        drain();

        apply_limits(20, 50, 10, 30);
        add_random_mix(210);
        drain();

        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
